// ===== hdl/websocket_client_frame_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the WebSocket client frame encoder checker
// Implication forms, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_CLIENT_FRAME_ENCODER_MACROS_SVH
`define WEBSOCKET_CLIENT_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication.
`define WCFE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcfe check failed: same-cycle rule");

// Next-cycle implication.
`define WCFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcfe check failed: next-cycle rule");

`endif

// ===== hdl/wcfe_pkg.sv =====
// ---------------------------------------------------------------------------
// wcfe_pkg
// Shared types, constants and helpers of the WebSocket client frame encoder.
// ---------------------------------------------------------------------------
package wcfe_pkg;

    // Input item kind, carried on s_tuser.
    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } op_t;

    // Kind of a queued command.
    typedef enum logic
    {
        CMD_HEADER = 1'b0,
        CMD_DATA   = 1'b1
    } cmd_kind_t;

    // One queued command: a full header, or one ready output byte.
    typedef struct packed
    {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic        err;
        logic [15:0] length;
        logic [3:0]  opcode;
        logic [31:0] key;
    } cmd_t;

    // s_tdata layout.
    localparam int S_TDATA_W     = 64;
    localparam int PB_LSB        = 0;
    localparam int LEN_LSB       = 8;
    localparam int OPC_LSB       = 24;
    localparam int KEY_LSB       = 28;

    // Frame constants.
    localparam logic [7:0]  FIN_BIT       = 8'h80;
    localparam logic [7:0]  MASK_BIT      = 8'h80;
    localparam logic [15:0] SHORT_LEN_MAX = 16'd125;
    localparam logic [6:0]  EXT16_CODE    = 7'd126;

    // Header step codes.
    localparam logic [2:0] HDR_OPCODE = 3'd0;
    localparam logic [2:0] HDR_LEN    = 3'd1;
    localparam logic [2:0] HDR_EXT_HI = 3'd2;
    localparam logic [2:0] HDR_EXT_LO = 3'd3;
    localparam logic [2:0] HDR_KEY0   = 3'd4;
    localparam logic [2:0] HDR_KEY3   = 3'd7;

    // Key byte for a position; position 0 is the most significant byte.
    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/wcfe_front.sv =====
// ---------------------------------------------------------------------------
// wcfe_front
// Accepts input beats, tracks the open frame and masks payload bytes.
// ---------------------------------------------------------------------------
module wcfe_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_kind,
    input  logic [wcfe_pkg::S_TDATA_W-1:0]       in_data,
    input  logic                                 queue_ready,
    output logic                                 push,
    output wcfe_pkg::cmd_t                       push_cmd
);

    logic [15:0] remaining_reg, remaining_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  pos_reg, pos_next;
    logic        open_reg, open_next;

    logic [7:0]  pb;
    logic [15:0] len;
    logic [3:0]  opc;
    logic [31:0] key;
    logic [15:0] rem_dec;

    assign pb      = in_data[wcfe_pkg::PB_LSB +: 8];
    assign len     = in_data[wcfe_pkg::LEN_LSB +: 16];
    assign opc     = in_data[wcfe_pkg::OPC_LSB +: 4];
    assign key     = in_data[wcfe_pkg::KEY_LSB +: 32];
    assign rem_dec = remaining_reg - 16'd1;
    assign push    = in_valid && queue_ready;

    always_comb
    begin
        remaining_next  = remaining_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        open_next       = open_reg;
        push_cmd        = '0;
        push_cmd.length = len;
        push_cmd.opcode = opc;
        push_cmd.key    = key;
        if (wcfe_pkg::op_t'(in_kind) == wcfe_pkg::OP_START)
        begin
            push_cmd.kind = wcfe_pkg::CMD_HEADER;
            if (push)
            begin
                remaining_next = len;
                key_next       = key;
                pos_next       = 2'd0;
                open_next      = (len != 16'd0);
            end
        end
        else if (!open_reg)
        begin
            // stray byte: error beat, state untouched
            push_cmd.kind = wcfe_pkg::CMD_DATA;
            push_cmd.err  = 1'b1;
        end
        else
        begin
            push_cmd.kind = wcfe_pkg::CMD_DATA;
            push_cmd.data = pb ^ wcfe_pkg::key_byte(key_reg, pos_reg);
            push_cmd.last = (rem_dec == 16'd0);
            if (push)
            begin
                remaining_next = rem_dec;
                pos_next       = pos_reg + 2'd1;
                open_next      = (rem_dec != 16'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            key_reg       <= '0;
            pos_reg       <= '0;
            open_reg      <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            key_reg       <= key_next;
            pos_reg       <= pos_next;
            open_reg      <= open_next;
        end
    end

endmodule

// ===== hdl/wcfe_queue.sv =====
// ---------------------------------------------------------------------------
// wcfe_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module wcfe_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wcfe_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           not_full,
    output logic           head_valid,
    output wcfe_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wcfe_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full   = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/wcfe_back.sv =====
// ---------------------------------------------------------------------------
// wcfe_back
// Expands header commands into bytes and drives the output register.
// ---------------------------------------------------------------------------
module wcfe_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  wcfe_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last,
    output logic           out_err
);

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;

    logic       load;
    logic       emit;
    logic       long_len;
    logic [7:0] hdr_byte;

    assign load     = !valid_reg || out_ready;
    assign emit     = head_valid && load;
    assign long_len = (head_cmd.length > wcfe_pkg::SHORT_LEN_MAX);

    always_comb
    begin
        case (step_reg)
            wcfe_pkg::HDR_OPCODE: hdr_byte = wcfe_pkg::FIN_BIT | {4'd0, head_cmd.opcode};
            wcfe_pkg::HDR_LEN:    hdr_byte = wcfe_pkg::MASK_BIT |
                                      {1'b0, long_len ? wcfe_pkg::EXT16_CODE
                                                      : head_cmd.length[6:0]};
            wcfe_pkg::HDR_EXT_HI: hdr_byte = head_cmd.length[15:8];
            wcfe_pkg::HDR_EXT_LO: hdr_byte = head_cmd.length[7:0];
            default:              hdr_byte = wcfe_pkg::key_byte(head_cmd.key, step_reg[1:0]);
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = emit;
        end
        if (emit)
        begin
            if (head_cmd.kind == wcfe_pkg::CMD_DATA)
            begin
                byte_next = head_cmd.data;
                last_next = head_cmd.last;
                err_next  = head_cmd.err;
                pop       = 1'b1;
            end
            else
            begin
                byte_next = hdr_byte;
                last_next = (step_reg == wcfe_pkg::HDR_KEY3) && (head_cmd.length == 16'd0);
                err_next  = 1'b0;
                if (step_reg == wcfe_pkg::HDR_KEY3)
                begin
                    pop       = 1'b1;
                    step_next = wcfe_pkg::HDR_OPCODE;
                end
                else if (step_reg == wcfe_pkg::HDR_LEN && !long_len)
                begin
                    step_next = wcfe_pkg::HDR_KEY0;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= wcfe_pkg::HDR_OPCODE;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_err   = err_reg;

endmodule

// ===== hdl/websocket_client_frame_encoder.sv =====
// ---------------------------------------------------------------------------
// websocket_client_frame_encoder
// Client-to-server WebSocket frame builder with payload masking.
// ---------------------------------------------------------------------------
//
//  channel  | direction | tdata                                   | tuser / tlast
//  ---------+-----------+-----------------------------------------+------------------------
//  s_       | in        | payload_byte, frame_length, opcode, key | tuser: operation
//  m_       | out       | out_byte                                | tlast: last_of_frame,
//           |           |                                         | tuser: stray_byte_error
//
//  Payload beats stream at one per clock while m_tready holds and the queue has room.
//  A start beat yields 6 output beats (length up to 125) or 8 (longer);
//  the back end emits one header byte per clock while m_tready holds.
//  The first output beat is presented after its input beat is accepted: queue
//  write at the accepting edge, then the output register load, which a stall delays.
//  s_tready drops only when the command queue (QUEUE_DEPTH entries) is full.
//  Reset clears the frame state, the queue and the output valid; no clear pass.
// ---------------------------------------------------------------------------
module websocket_client_frame_encoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] payload_byte, [23:8] frame_length, [27:24] frame_opcode,
    // [59:28] mask_key, [63:60] zero
    input  logic [63:0] s_tdata,
    // [0] operation
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // [0] stray_byte_error
    output logic        m_tuser
);

    logic           push;
    wcfe_pkg::cmd_t push_cmd;
    logic           pop;
    logic           head_valid;
    wcfe_pkg::cmd_t head_cmd;
    logic           queue_ready;

    // Front: hold frame state, mask payload bytes as they arrive.
    wcfe_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_kind     (s_tuser),
        .in_data     (s_tdata),
        .queue_ready (queue_ready),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    assign s_tready = queue_ready;

    // Queue: decouple accepted beats from output stalls.
    wcfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .not_full   (queue_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: advance through header bytes, drive the output register.
    wcfe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_err    (m_tuser)
    );

endmodule

// ===== hdl/wcfe_checker.sv =====
// ---------------------------------------------------------------------------
// wcfe_checker
// Port-level checks on the frame encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "websocket_client_frame_encoder_macros.svh"

module wcfe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic in_idle;
    assign in_idle = !s_tvalid && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    // a stalled beat keeps valid and its contents
    `WCFE_ASSERT_NEXT(a_out_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `WCFE_ASSERT_NEXT(a_out_hold_data, m_tvalid && !m_tready,
                      $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    // an error beat carries a zero byte and never closes a frame
    `WCFE_ASSERT_NOW(a_err_beat_clean, m_tvalid && m_tuser, m_tdata == 8'd0 && !m_tlast)
    // with the output register empty the queue cannot be full
    `WCFE_ASSERT_NOW(a_ready_when_drained, !m_tvalid || in_idle, s_tready || m_tvalid)

endmodule

bind websocket_client_frame_encoder wcfe_checker u_wcfe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
